@@ rtl/psgrsp_pkg.sv @@
// Shared types, codes and helper functions of the sound register stream player.
// Used by psgrsp_seq and psg_register_stream_player; depends on nothing else.

package psgrsp_pkg;

    localparam int unsigned STORE_DEPTH_DEFAULT = 65536;
    localparam int unsigned MAX_WRITES_DEFAULT  = 63;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_PLAY  = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_SILENCE = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;

    localparam logic [1:0] CFG_TRACK_START = 2'd0;
    localparam logic [1:0] CFG_TRACK_END   = 2'd1;
    localparam logic [1:0] CFG_LOOP_TARGET = 2'd2;
    localparam logic [1:0] CFG_LOOP_ENABLE = 2'd3;

    localparam logic [7:0] BYTE_END = 8'hFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_OP_WAIT,
        S_VAL_WAIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] reg_index;
        logic [7:0] reg_value;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [15:0] track_start;
        logic [15:0] track_end;
        logic [15:0] loop_target;
        logic        loop_enable;
    } cfg_t;

    // Reduces a 16-bit offset modulo the store depth. A power-of-two depth is a mask;
    // otherwise eight restoring compare-subtract steps cover every quotient below 256.
    function automatic logic [15:0] store_index(logic [15:0] off, int unsigned depth);
        logic [23:0] r;
        logic [23:0] d;
        r = {8'd0, off};
        if ((depth & (depth - 1)) == 0) begin
            return off & 16'(depth - 1);
        end
        for (int k = 7; k >= 0; k--) begin
            d = 24'(depth) << k;
            if (r >= d) begin
                r = r - d;
            end
        end
        return r[15:0];
    endfunction

endpackage

@@ rtl/psgrsp_seq.sv @@
// Stream store and decode sequencer of the sound register stream player.
// Depends on psgrsp_pkg; results are handed to the output register of the top level.

module psgrsp_seq #(
    parameter int unsigned STORE_DEPTH         = psgrsp_pkg::STORE_DEPTH_DEFAULT,
    parameter int unsigned MAX_WRITES_PER_TICK = psgrsp_pkg::MAX_WRITES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [15:0]        write_address,
    input  logic [7:0]         write_data,
    input  psgrsp_pkg::cfg_t   cfg,
    input  logic               out_free,
    output logic               push,
    output psgrsp_pkg::res_t   res
);

    localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
    localparam int unsigned WCNT_W = $clog2(MAX_WRITES_PER_TICK + 1);
    localparam logic [WCNT_W-1:0] WRITE_CAP = WCNT_W'(MAX_WRITES_PER_TICK);

    psgrsp_pkg::state_t state_reg, state_next;
    logic [15:0]        offset_reg, offset_next;
    logic [6:0]         delay_reg, delay_next;
    logic               playing_reg, playing_next;
    logic [WCNT_W-1:0]  writes_reg, writes_next;
    logic [5:0]         idx_reg, idx_next;
    logic               pend_valid_reg, pend_valid_next;
    psgrsp_pkg::res_t   pend_reg, pend_next;

    logic [7:0]         store_mem [STORE_DEPTH];
    logic [7:0]         rd_data_reg;
    logic               mem_we;
    logic               mem_re;
    logic [15:0]        wr_full_idx;
    logic [15:0]        rd_full_idx;
    logic [ADDR_W-1:0]  wr_idx;
    logic [ADDR_W-1:0]  rd_idx;

    psgrsp_pkg::res_t   res_none;
    psgrsp_pkg::res_t   res_silence;

    assign wr_full_idx = psgrsp_pkg::store_index(write_address, STORE_DEPTH);
    assign rd_full_idx = psgrsp_pkg::store_index(offset_reg, STORE_DEPTH);
    assign wr_idx      = wr_full_idx[ADDR_W-1:0];
    assign rd_idx      = rd_full_idx[ADDR_W-1:0];

    assign res_none    = '{kind: psgrsp_pkg::KIND_NONE, reg_index: 6'd0,
                           reg_value: 8'd0, last: 1'b1};
    assign res_silence = '{kind: psgrsp_pkg::KIND_SILENCE, reg_index: 6'd0,
                           reg_value: 8'd0, last: 1'b1};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wr_idx] <= write_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= psgrsp_pkg::S_IDLE;
            offset_reg     <= 16'd0;
            delay_reg      <= 7'd0;
            playing_reg    <= 1'b0;
            writes_reg     <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            offset_reg     <= offset_next;
            delay_reg      <= delay_next;
            playing_reg    <= playing_next;
            writes_reg     <= writes_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        pend_reg <= pend_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        offset_next     = offset_reg;
        delay_next      = delay_reg;
        playing_next    = playing_reg;
        writes_next     = writes_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        in_stall        = 1'b1;
        push            = 1'b0;
        res             = res_none;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        case (state_reg)
            psgrsp_pkg::S_IDLE:
            begin
                in_stall = !out_free;
                if (in_valid && out_free)
                begin
                    case (command)
                        psgrsp_pkg::CMD_TICK:
                        begin
                            if (!playing_reg)
                            begin
                                push = 1'b1;
                            end
                            else if (delay_reg != 7'd0)
                            begin
                                delay_next = delay_reg - 7'd1;
                                push       = 1'b1;
                            end
                            else
                            begin
                                writes_next = '0;
                                state_next  = psgrsp_pkg::S_OP;
                            end
                        end
                        psgrsp_pkg::CMD_WRITE:
                        begin
                            mem_we = 1'b1;
                            push   = 1'b1;
                        end
                        psgrsp_pkg::CMD_PLAY:
                        begin
                            offset_next  = cfg.track_start;
                            delay_next   = 7'd0;
                            playing_next = 1'b1;
                            push         = 1'b1;
                            res          = res_silence;
                        end
                        default:
                        begin
                            playing_next = 1'b0;
                            push         = 1'b1;
                            res          = res_silence;
                        end
                    endcase
                end
            end

            psgrsp_pkg::S_OP:
            begin
                if (writes_reg == WRITE_CAP)
                begin
                    state_next = psgrsp_pkg::S_FINISH;
                end
                else if (offset_reg >= cfg.track_end)
                begin
                    if (cfg.loop_enable)
                    begin
                        offset_next = cfg.loop_target;
                        delay_next  = 7'd0;
                        state_next  = psgrsp_pkg::S_FINISH;
                    end
                    else if (!pend_valid_reg || out_free)
                    begin
                        push            = pend_valid_reg;
                        res             = pend_reg;
                        pend_next       = res_silence;
                        pend_valid_next = 1'b1;
                        playing_next    = 1'b0;
                        state_next      = psgrsp_pkg::S_FINISH;
                    end
                end
                else
                begin
                    mem_re      = 1'b1;
                    offset_next = offset_reg + 16'd1;
                    state_next  = psgrsp_pkg::S_OP_WAIT;
                end
            end

            psgrsp_pkg::S_OP_WAIT:
            begin
                if (rd_data_reg == psgrsp_pkg::BYTE_END)
                begin
                    if (cfg.loop_enable)
                    begin
                        offset_next = cfg.loop_target;
                        delay_next  = 7'd0;
                        state_next  = psgrsp_pkg::S_FINISH;
                    end
                    else if (!pend_valid_reg || out_free)
                    begin
                        push            = pend_valid_reg;
                        res             = pend_reg;
                        pend_next       = res_silence;
                        pend_valid_next = 1'b1;
                        playing_next    = 1'b0;
                        state_next      = psgrsp_pkg::S_FINISH;
                    end
                end
                else if (rd_data_reg[7])
                begin
                    idx_next    = rd_data_reg[5:0];
                    mem_re      = 1'b1;
                    offset_next = offset_reg + 16'd1;
                    state_next  = psgrsp_pkg::S_VAL_WAIT;
                end
                else
                begin
                    delay_next = rd_data_reg[6:0];
                    state_next = psgrsp_pkg::S_FINISH;
                end
            end

            psgrsp_pkg::S_VAL_WAIT:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    push            = pend_valid_reg;
                    res             = pend_reg;
                    pend_next       = '{kind: psgrsp_pkg::KIND_WRITE, reg_index: idx_reg,
                                        reg_value: rd_data_reg, last: 1'b1};
                    pend_valid_next = 1'b1;
                    writes_next     = writes_reg + WCNT_W'(1);
                    state_next      = psgrsp_pkg::S_OP;
                end
            end

            psgrsp_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    push            = 1'b1;
                    res             = pend_valid_reg ? pend_reg : res_none;
                    pend_valid_next = 1'b0;
                    state_next      = psgrsp_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = psgrsp_pkg::S_IDLE;
            end
        endcase

        // A held result is only final when the sequencer reaches its finish step.
        if (push && state_reg != psgrsp_pkg::S_IDLE && state_reg != psgrsp_pkg::S_FINISH)
        begin
            res.last = 1'b0;
        end
    end

endmodule

@@ rtl/psg_register_stream_player.sv @@
// Top level of the sound register stream player: configuration registers and output word.
// Depends on psgrsp_pkg and psgrsp_seq.
//
// Usage: load the stream with write commands (one word each), set the track registers
// through the configuration port while idle, then send play, frame ticks and stop.
// Every input word gives one or more output words; the final one carries last.
// Input and output use valid/stall handshakes; an output register separates the sides.
// Write, play, stop and idle or delaying ticks are handled in the idle state: the result
// appears in the output register the cycle after the input word is accepted.
// A decoding tick reads the store through one synchronous port: a register write passes
// the op, op wait and value wait states, a delay or end byte the op and op wait states,
// and the write cap check the op state alone, before the finish state returns to idle.
// While a tick decodes, the input is stalled; while the receiver stalls the output,
// the sequencer holds at its next result and loses nothing.
// Reset clears playback state, configuration and the output valid; the store
// contents stay undefined until written.

module psg_register_stream_player #(
    parameter int unsigned STORE_DEPTH         = psgrsp_pkg::STORE_DEPTH_DEFAULT,
    parameter int unsigned MAX_WRITES_PER_TICK = psgrsp_pkg::MAX_WRITES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [15:0] write_address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [5:0]  reg_index,
    output logic [7:0]  reg_value,
    output logic        last,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    psgrsp_pkg::cfg_t cfg_reg, cfg_next;
    psgrsp_pkg::res_t out_reg;
    psgrsp_pkg::res_t seq_res;
    logic             out_valid_reg;
    logic             out_free;
    logic             seq_push;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                psgrsp_pkg::CFG_TRACK_START: cfg_next.track_start = cfg_data;
                psgrsp_pkg::CFG_TRACK_END:   cfg_next.track_end   = cfg_data;
                psgrsp_pkg::CFG_LOOP_TARGET: cfg_next.loop_target = cfg_data;
                psgrsp_pkg::CFG_LOOP_ENABLE: cfg_next.loop_enable = cfg_data[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (seq_push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_push)
        begin
            out_reg <= seq_res;
        end
    end

    psgrsp_seq #(
        .STORE_DEPTH         (STORE_DEPTH),
        .MAX_WRITES_PER_TICK (MAX_WRITES_PER_TICK)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .write_address (write_address),
        .write_data    (write_data),
        .cfg           (cfg_reg),
        .out_free      (out_free),
        .push          (seq_push),
        .res           (seq_res)
    );

    assign out_valid = out_valid_reg;
    assign kind      = out_reg.kind;
    assign reg_index = out_reg.reg_index;
    assign reg_value = out_reg.reg_value;
    assign last      = out_reg.last;

endmodule

@@ tb/sv/psgrsp_checker.sv @@
// Checker for psg_register_stream_player: watches the input, output and configuration ports,
// keeps its own copy of the player state and compares every result word in order.
// Depends on psgrsp_pkg for command, kind and register codes and the result word type.
`timescale 1ns / 1ps

module psgrsp_checker #(
    parameter int unsigned STORE_DEPTH = psgrsp_pkg::STORE_DEPTH_DEFAULT,
    parameter int unsigned MAX_WRITES  = psgrsp_pkg::MAX_WRITES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  command,
    input  logic [15:0] write_address,
    input  logic [7:0]  write_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [5:0]  reg_index,
    input  logic [7:0]  reg_value,
    input  logic        last,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          pending,
    output int          failures,
    output int          results_seen
);

    import psgrsp_pkg::*;

    logic [7:0]  store_copy [STORE_DEPTH];
    logic [15:0] play_offset;
    logic [6:0]  delay_left;
    logic        is_playing;
    cfg_t        track_cfg;
    res_t        expected_words [$];
    int          fail_total;
    int          checked_total;

    initial
    begin
        fail_total = 0;
        checked_total = 0;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            store_copy[i] = 8'h00;
        end
    end

    function automatic logic [7:0] stored_byte(logic [15:0] off);
        return store_copy[int'(off) % STORE_DEPTH];
    endfunction

    task automatic report_mismatch(string msg);
        fail_total++;
        if (fail_total <= 50)
        begin
            $display("%0t ns mismatch: %s", $time, msg);
        end
    endtask

    task automatic expect_word(logic [1:0] k, logic [5:0] idx, logic [7:0] val);
        res_t w;
        w.kind = k;
        w.reg_index = idx;
        w.reg_value = val;
        w.last = 1'b0;
        expected_words.push_back(w);
    endtask

    task automatic close_item(int first_new);
        res_t w;
        if (expected_words.size() == first_new)
        begin
            expect_word(KIND_NONE, 6'd0, 8'd0);
        end
        w = expected_words.pop_back();
        w.last = 1'b1;
        expected_words.push_back(w);
    endtask

    task automatic decode_frame();
        int         writes;
        bit         done;
        logic [7:0] op;
        logic [7:0] value;
        writes = 0;
        done = 1'b0;
        if (!is_playing)
        begin
            done = 1'b1;
        end
        else if (delay_left != 7'd0)
        begin
            delay_left = delay_left - 7'd1;
            done = 1'b1;
        end
        while (!done && writes < MAX_WRITES)
        begin
            if (play_offset >= track_cfg.track_end)
            begin
                op = BYTE_END;
            end
            else
            begin
                op = stored_byte(play_offset);
                play_offset = play_offset + 16'd1;
            end
            if (op == BYTE_END)
            begin
                if (track_cfg.loop_enable)
                begin
                    play_offset = track_cfg.loop_target;
                    delay_left = 7'd0;
                end
                else
                begin
                    is_playing = 1'b0;
                    expect_word(KIND_SILENCE, 6'd0, 8'd0);
                end
                done = 1'b1;
            end
            else if (op >= 8'h80)
            begin
                value = stored_byte(play_offset);
                play_offset = play_offset + 16'd1;
                expect_word(KIND_WRITE, op[5:0], value);
                writes++;
            end
            else
            begin
                delay_left = op[6:0];
                done = 1'b1;
            end
        end
    endtask

    task automatic take_word(logic [1:0] cmd, logic [15:0] addr, logic [7:0] data);
        int first_new;
        first_new = expected_words.size();
        case (cmd)
            CMD_TICK:
            begin
                decode_frame();
            end
            CMD_WRITE:
            begin
                store_copy[int'(addr) % STORE_DEPTH] = data;
            end
            CMD_PLAY:
            begin
                play_offset = track_cfg.track_start;
                delay_left = 7'd0;
                is_playing = 1'b1;
                expect_word(KIND_SILENCE, 6'd0, 8'd0);
            end
            default:
            begin
                is_playing = 1'b0;
                expect_word(KIND_SILENCE, 6'd0, 8'd0);
            end
        endcase
        close_item(first_new);
    endtask

    task automatic check_word();
        res_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word kind=%0d index=%0d value=%0h last=%0b",
                                      kind, reg_index, reg_value, last));
        end
        else
        begin
            want = expected_words.pop_front();
            checked_total++;
            if (kind !== want.kind || reg_index !== want.reg_index ||
                reg_value !== want.reg_value || last !== want.last)
            begin
                report_mismatch($sformatf(
                    "got kind=%0d index=%0d value=%0h last=%0b, want %0d %0d %0h %0b",
                    kind, reg_index, reg_value, last,
                    want.kind, want.reg_index, want.reg_value, want.last));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_offset = 16'd0;
            delay_left = 7'd0;
            is_playing = 1'b0;
            track_cfg = '0;
            expected_words.delete();
            pending <= 0;
            failures <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_TRACK_START: track_cfg.track_start = cfg_data;
                    CFG_TRACK_END:   track_cfg.track_end = cfg_data;
                    CFG_LOOP_TARGET: track_cfg.loop_target = cfg_data;
                    default:         track_cfg.loop_enable = cfg_data[0];
                endcase
            end
            if (in_valid && !in_stall)
            begin
                take_word(command, write_address, write_data);
            end
            if (out_valid && !out_stall)
            begin
                check_word();
            end
            pending <= expected_words.size();
            failures <= fail_total;
            results_seen <= checked_total;
        end
    end

endmodule

@@ tb/sv/tb.sv @@
// Top of the psg_register_stream_player testbench: clock, reset, stimulus and verdict.
// Drives directed and random track phases; psgrsp_checker predicts and compares the results.
// Depends on psgrsp_pkg, psgrsp_checker and the player RTL.
`timescale 1ns / 1ps

module tb;

    import psgrsp_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [5:0]  reg_index;
    logic [7:0]  reg_value;
    logic        last;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int pending;
    int failures;
    int results_seen;
    int words_sent = 0;
    int tick_words = 0;
    int phase_count = 0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;

    psg_register_stream_player u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .write_address (write_address),
        .write_data    (write_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .reg_index     (reg_index),
        .reg_value     (reg_value),
        .last          (last),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    psgrsp_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .write_address (write_address),
        .write_data    (write_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .reg_index     (reg_index),
        .reg_value     (reg_value),
        .last          (last),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending       (pending),
        .failures      (failures),
        .results_seen  (results_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #500_000_000;
        $display("FAIL psg_register_stream_player");
        $finish;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [7:0] delay_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 8'($urandom_range(0, 3));
        else if (r < 95)
            return 8'($urandom_range(4, 20));
        else if (r < 98)
            return 8'h7F;
        return 8'($urandom_range(21, 127));
    endfunction

    // Receiver: random stalls, plus one long hold-off so the player backs up into its input.
    initial
    begin : receiver
        int gap;
        bit held_off;
        out_stall = 1'b0;
        held_off = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!held_off && words_sent >= 80)
            begin
                held_off = 1'b1;
                gap = 400;
            end
            else
            begin
                gap = rx_quiet ? 0 : idle_gap();
            end
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    end

    task automatic send_word(logic [1:0] cmd, logic [15:0] addr, logic [7:0] data);
        int gap;
        gap = tx_quiet ? 0 : idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        write_address <= addr;
        write_data <= data;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (cmd == CMD_TICK)
            tick_words++;
    endtask

    task automatic wait_idle(int extra);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_track(logic [15:0] start, logic [15:0] stop_at, logic [15:0] target,
                             logic looping);
        cfg_write <= 1'b1;
        cfg_index <= CFG_TRACK_START;
        cfg_data <= start;
        @(posedge clk);
        cfg_index <= CFG_TRACK_END;
        cfg_data <= stop_at;
        @(posedge clk);
        cfg_index <= CFG_LOOP_TARGET;
        cfg_data <= target;
        @(posedge clk);
        cfg_index <= CFG_LOOP_ENABLE;
        cfg_data <= {15'd0, looping};
        @(posedge clk);
        cfg_write <= 1'b0;
        phase_count++;
    endtask

    // Writes len + 1 bytes so that a value byte sitting at the end offset is also defined.
    task automatic load_track(logic [15:0] base, int len, bit cap_run);
        logic [7:0] track_bytes [$];
        int         r;
        int         pairs;
        pairs = 0;
        while (track_bytes.size() <= len)
        begin
            r = $urandom_range(0, 99);
            if (cap_run)
            begin
                if (pairs < 70)
                begin
                    track_bytes.push_back(8'($urandom_range(8'h80, 8'hFE)));
                    track_bytes.push_back(8'($urandom));
                    pairs++;
                end
                else
                begin
                    track_bytes.push_back(BYTE_END);
                end
            end
            else if (r < 60)
            begin
                track_bytes.push_back(8'($urandom_range(8'h80, 8'hFE)));
                track_bytes.push_back(8'($urandom));
            end
            else if (r < 85)
            begin
                track_bytes.push_back(delay_byte());
            end
            else if (r < 90)
            begin
                track_bytes.push_back(BYTE_END);
            end
            else
            begin
                track_bytes.push_back(8'($urandom));
            end
        end
        for (int i = 0; i <= len; i++)
        begin
            send_word(CMD_WRITE, base + 16'(i), track_bytes[i]);
        end
    endtask

    task automatic run_phase(bit cap_run);
        int          len;
        int          ticks;
        int          r;
        logic [15:0] base;
        logic [15:0] start;
        logic [15:0] stop_at;
        logic [15:0] target;
        logic        looping;
        looping = 1'($urandom_range(0, 1));
        tx_quiet = ($urandom_range(0, 9) < 3);
        rx_quiet = ($urandom_range(0, 9) < 3);
        if (cap_run)
            len = 140;
        else if ($urandom_range(0, 9) == 0)
            len = 0;
        else
            len = $urandom_range(4, 24);
        base = 16'($urandom_range(0, 16'hFF00));
        if (len == 0)
        begin
            stop_at = base;
            start = base + 16'($urandom_range(0, 5));
            target = 16'($urandom_range(stop_at, 16'hFFFF));
        end
        else
        begin
            start = base;
            stop_at = base + 16'(len);
            if ($urandom_range(0, 3) == 0)
                target = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                     : 16'($urandom_range(stop_at, 16'hFFFF));
            else
                target = base + 16'($urandom_range(0, len - 1));
        end
        wait_idle(4);
        set_track(start, stop_at, target, looping);
        if (len > 0)
            load_track(base, len, cap_run);
        send_word(CMD_PLAY, 16'($urandom), 8'($urandom));
        ticks = cap_run ? 4 : $urandom_range(4, 30);
        repeat (ticks)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                send_word(CMD_WRITE, 16'($urandom), 8'($urandom));
            else if (r < 8)
                send_word(CMD_PLAY, 16'($urandom), 8'($urandom));
            else if (r < 11)
                send_word(CMD_STOP, 16'($urandom), 8'($urandom));
            send_word(CMD_TICK, 16'($urandom), 8'($urandom));
        end
        if ($urandom_range(0, 1) == 1)
            send_word(CMD_STOP, 16'($urandom), 8'($urandom));
    endtask

    initial
    begin : stimulus
        int random_start;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_TICK;
        write_address = 16'd0;
        write_data = 8'd0;
        cfg_write = 1'b0;
        cfg_index = CFG_TRACK_START;
        cfg_data = 16'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(CMD_TICK, 16'h0000, 8'h00);
        send_word(CMD_STOP, 16'hFFFF, 8'hFF);

        // The track runs off the top of the offset range and continues from zero.
        wait_idle(4);
        set_track(16'hFFFC, 16'hFFFF, 16'h0000, 1'b0);
        send_word(CMD_WRITE, 16'hFFFC, 8'hBF);
        send_word(CMD_WRITE, 16'hFFFD, 8'hFF);
        send_word(CMD_WRITE, 16'hFFFE, 8'h80);
        send_word(CMD_WRITE, 16'hFFFF, 8'h00);
        send_word(CMD_WRITE, 16'h0000, 8'h00);
        send_word(CMD_WRITE, 16'h0001, 8'hFF);
        send_word(CMD_PLAY, 16'h0000, 8'h00);
        repeat (3) send_word(CMD_TICK, 16'hFFFF, 8'hFF);

        // A looping track whose last value byte lies on the end offset.
        wait_idle(4);
        set_track(16'h0010, 16'h0014, 16'h0012, 1'b1);
        send_word(CMD_WRITE, 16'h0010, 8'h85);
        send_word(CMD_WRITE, 16'h0011, 8'h5A);
        send_word(CMD_WRITE, 16'h0012, 8'h01);
        send_word(CMD_WRITE, 16'h0013, 8'hA3);
        send_word(CMD_WRITE, 16'h0014, 8'h77);
        send_word(CMD_PLAY, 16'h5555, 8'hAA);
        repeat (4) send_word(CMD_TICK, 16'hAAAA, 8'h55);
        send_word(CMD_PLAY, 16'h0000, 8'h00);
        send_word(CMD_STOP, 16'h0000, 8'h00);

        random_start = words_sent;
        run_phase(1'b1);
        while (words_sent - random_start < 300)
        begin
            run_phase(1'b0);
        end

        tx_quiet = 1'b0;
        wait_idle(3 * MAX_WRITES_DEFAULT + 8);
        $display("Run covered %0d input words (%0d frame ticks) over %0d track settings.",
                 words_sent, tick_words, phase_count);
        $display("Checked %0d result words, including a write cap run, wrap and loop tracks.",
                 results_seen);
        if (failures == 0)
            $display("PASS psg_register_stream_player");
        else
            $display("FAIL psg_register_stream_player");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/psgrsp_pkg.sv
rtl/psgrsp_seq.sv
rtl/psg_register_stream_player.sv
tb/sv/psgrsp_checker.sv
tb/sv/tb.sv
